/* rtl/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths and defaults for the sliding window average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int DEFAULT_WINDOW = 8;
  localparam int SAMPLE_W       = 32;
  localparam int STAMP_W        = 63;

endpackage

`default_nettype wire

/* rtl/sliding_window_average_unit.sv */
// An accepted sample moves S_IDLE to S_LOAD, then S_DIV and S_DONE; the result is registered on finish.
// A new sample is taken only in S_IDLE, after the previous one finishes, as the bit-serial
//   divider retires one dividend bit per cycle (DVD_W = 33 + clog2(WINDOW+1)).
// A finished result waits in the output register while the next one is taken.
// Reset (rst, synchronous): count, ring pointer and running mean cleared; history not cleared.
// ----------------------------------------------------------------------------
// sliding_window_average_unit
// Running average of a Q16.16 stream with warm-up, history kept in a ring RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average_unit #(
  parameter int WINDOW = swa_pkg::DEFAULT_WINDOW
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [swa_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [swa_pkg::STAMP_W-1:0]  stamp,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [swa_pkg::SAMPLE_W-1:0]    mean,
  output logic        [swa_pkg::STAMP_W-1:0]     stamp_out
);

  localparam int SW     = swa_pkg::SAMPLE_W;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DVD_W  = SW + CNT_W + 1;
  localparam int ITER_W = $clog2(DVD_W);

  localparam logic [CNT_W-1:0]  WIN_CNT   = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DVD_W - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]              state;
  logic [SLOT_W-1:0]       write_slot;
  logic [CNT_W-1:0]        seen_count;
  logic signed [SW-1:0]    running_mean;

  logic signed [SW-1:0]    history [WINDOW];
  logic signed [SW-1:0]    oldest;

  logic signed [SW-1:0]    sample_q;
  logic [swa_pkg::STAMP_W-1:0] stamp_q;
  logic signed [DVD_W-1:0] prod;
  logic                    warm;

  logic [DVD_W-1:0]        quo;
  logic [CNT_W-1:0]        rem;
  logic [CNT_W-1:0]        divisor;
  logic                    neg;
  logic [ITER_W-1:0]       iter;

  logic signed [DVD_W-1:0] dividend;
  logic [DVD_W-1:0]        dvd_mag;
  logic [CNT_W:0]          shifted;
  logic                    take;
  logic signed [SW:0]      q_signed;
  logic signed [SW+1:0]    sum;
  logic signed [SW-1:0]    mean_next;
  logic                    accept;
  logic                    finish;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_DONE) && (!out_valid || out_ready);

  // dividend formed once the ring read returns
  always_comb begin
    if (warm) begin
      dividend = prod + DVD_W'(sample_q);
    end else begin
      dividend = DVD_W'(sample_q) - DVD_W'(oldest);
    end
    dvd_mag = dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
  end

  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    take    = (shifted >= {1'b0, divisor});
  end

  always_comb begin
    q_signed = neg ? -$signed({1'b0, quo[SW-1:0]}) : $signed({1'b0, quo[SW-1:0]});
    if (warm) begin
      sum = (SW+2)'(q_signed);
    end else begin
      sum = (SW+2)'(running_mean) + (SW+2)'(q_signed);
    end
    if (sum > (SW+2)'(signed'({2'b00, {(SW-1){1'b1}}}))) begin
      mean_next = {1'b0, {(SW-1){1'b1}}};
    end else if (sum < (SW+2)'(signed'({2'b11, {(SW-1){1'b0}}}))) begin
      mean_next = {1'b1, {(SW-1){1'b0}}};
    end else begin
      mean_next = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oldest <= history[write_slot];
    end
    if (finish) begin
      history[write_slot] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= sample;
      stamp_q  <= stamp;
      warm     <= (seen_count < WIN_CNT);
      prod     <= DVD_W'(running_mean) * DVD_W'($signed({1'b0, seen_count}));
    end
    if (state == S_LOAD) begin
      quo     <= dvd_mag;
      neg     <= dividend[DVD_W-1];
      rem     <= '0;
      divisor <= warm ? seen_count + CNT_W'(1) : WIN_CNT;
    end else if (state == S_DIV) begin
      rem <= take ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
      quo <= {quo[DVD_W-2:0], take};
    end
    if (finish) begin
      mean      <= mean_next;
      stamp_out <= stamp_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      iter         <= '0;
      write_slot   <= '0;
      seen_count   <= '0;
      running_mean <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          iter  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          iter <= iter + ITER_W'(1);
          if (iter == ITER_LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (finish) begin
            running_mean <= mean_next;
            write_slot   <= (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);
            if (warm) begin
              seen_count <= seen_count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seen_count <= WIN_CNT)
    else $error("seen count beyond window");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> divisor != '0)
    else $error("zero divisor in divide loop");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_LOAD)
    else $error("accepted transaction did not start");
`endif

endmodule

`default_nettype wire

/* tb/sliding_window_average_unit_test.sv */
// ----------------------------------------------------------------------------
// sliding_window_average_unit_test
// Self-checking bench for the sliding window average unit. Samples go in
// over a valid/ready channel and are mirrored by an in-bench running-average
// predictor (warm-up division, then ring-based window update, saturation).
// Each output transaction is checked in order against the predicted mean and
// the passed-through stamp. Both channels idle at random outside the no-idle stretch.
// ----------------------------------------------------------------------------
module sliding_window_average_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = swa_pkg::SAMPLE_W;
  localparam int STAMP_W      = swa_pkg::STAMP_W;
  localparam int WINDOW       = swa_pkg::DEFAULT_WINDOW;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 60;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh80000000;
  localparam longint MEAN_MAX = 64'sd2147483647;
  localparam longint MEAN_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] avg;
    logic [STAMP_W-1:0]         ts;
  } mean_rec_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [STAMP_W-1:0]         stamp;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic [STAMP_W-1:0]         stamp_out;

  // running-average mirror
  logic signed [SAMPLE_W-1:0] ring_hist [WINDOW];
  int                         ring_slot;
  int                         fill_count;
  logic signed [SAMPLE_W-1:0] avg_q;

  mean_rec_t pending_means [$];
  int        error_count;
  int        cycle_count;
  bit        no_idle;

  sliding_window_average_unit #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .stamp     (stamp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mean      (mean),
    .stamp_out (stamp_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = no_idle || ($urandom_range(0, 99) >= 22);
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] update_average(
    input logic signed [SAMPLE_W-1:0] x
  );
    longint xv;
    longint n;
    longint nxt;
    xv = longint'(x);
    if (fill_count < WINDOW) begin
      n = longint'(fill_count);
      nxt = (longint'(avg_q) * n + xv) / (n + 1);
      fill_count++;
    end else begin
      nxt = longint'(avg_q) + (xv - longint'(ring_hist[ring_slot])) / WINDOW;
    end
    if (nxt > MEAN_MAX) nxt = MEAN_MAX;
    else if (nxt < MEAN_MIN) nxt = MEAN_MIN;
    avg_q = nxt[SAMPLE_W-1:0];
    ring_hist[ring_slot] = x;
    ring_slot = (ring_slot + 1) % WINDOW;
    return avg_q;
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[STAMP_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return $urandom;
    if (pick < 60) return $urandom_range(0, 512) - 256;
    if (pick < 75) return SAMPLE_MAX - $urandom_range(0, 4095);
    if (pick < 90) return SAMPLE_MIN + $urandom_range(0, 4095);
    return pick[0] ? SAMPLE_MAX : SAMPLE_MIN;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic [STAMP_W-1:0] ts);
    mean_rec_t rec;
    while (!no_idle && $urandom_range(0, 99) < 22) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample   = x;
    stamp    = ts;
    do @(posedge clk); while (in_ready !== 1'b1);
    rec.avg = update_average(x);
    rec.ts  = ts;
    pending_means.push_back(rec);
    @(negedge clk);
  endtask

  task automatic drain_results(input int tail);
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    mean_rec_t head;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_means.size() == 0) begin
        report_error($sformatf("unexpected transaction mean=%h stamp=%h", mean, stamp_out));
      end else begin
        head = pending_means.pop_front();
        if (mean !== head.avg)
          report_error($sformatf("mean got %h want %h", mean, head.avg));
        if (stamp_out !== head.ts)
          report_error($sformatf("stamp_out got %h want %h", stamp_out, head.ts));
      end
    end
  end

  // first sample, warm-up with mixed signs, then window-full updates at the rails
  task automatic test_warmup_and_extremes();
    logic signed [SAMPLE_W-1:0] vals [18] = '{
      32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
      32'sh00000001, 32'sh00010000, 32'shFFFF0000, 32'sh00000003,
      32'shFFFFFFFD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh55555555,
      32'shAAAAAAAA, 32'sh00000007, 32'shFFFFFFF9, 32'sh7FFF0000,
      32'sh80010000, 32'sh00000000
    };
    logic [STAMP_W-1:0] ts;
    for (int k = 0; k < 18; k++) begin
      case (k)
        0: ts = '0;
        1: ts = '1;
        2: ts = 63'h2AAAAAAAAAAAAAAA;
        3: ts = 63'h5555555555555555;
        default: ts = 63'd1 << (k * 3);
      endcase
      send_sample(vals[k], ts);
    end
    drain_results(0);
  endtask

  // walk history away from the mean without moving it, until the next rail
  // sample pushes the window update past the 32-bit range
  task automatic drive_to_rail(input bit high);
    logic signed [SAMPLE_W-1:0] rail;
    logic signed [SAMPLE_W-1:0] x;
    longint oldest;
    longint proj;
    bit done;
    rail = high ? SAMPLE_MAX : SAMPLE_MIN;
    for (int k = 0; k < WINDOW; k++) send_sample(rail, rand_stamp());
    done = 1'b0;
    for (int k = 0; k < 400 && !done; k++) begin
      oldest = longint'(ring_hist[ring_slot]);
      proj = longint'(avg_q) + (longint'(rail) - oldest) / WINDOW;
      if (high ? (proj > MEAN_MAX) : (proj < MEAN_MIN)) begin
        send_sample(rail, rand_stamp());
        done = 1'b1;
      end else begin
        x = SAMPLE_W'(high ? oldest - $urandom_range(1, 7) : oldest + $urandom_range(1, 7));
        send_sample(x, rand_stamp());
      end
    end
  endtask

  task automatic test_rail_saturation();
    drive_to_rail(1'b1);
    drive_to_rail(1'b0);
    drive_to_rail(1'b1);
    drain_results(0);
  endtask

  task automatic test_random_stream();
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 500 && k < 700);
      if (k == 900) drain_results(0);
      send_sample(rand_sample(), rand_stamp());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample      = '0;
    stamp       = '0;
    no_idle     = 1'b0;
    error_count = 0;
    cycle_count = 0;
    ring_slot   = 0;
    fill_count  = 0;
    avg_q       = '0;
    for (int k = 0; k < WINDOW; k++) ring_hist[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_warmup_and_extremes();
    test_rail_saturation();
    test_random_stream();
    drain_results(TAIL_CYCLES);

    if (error_count == 0 && pending_means.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swa_pkg.sv
rtl/sliding_window_average_unit.sv
tb/sliding_window_average_unit_test.sv
